[rtl/gbci_pkg.sv]
package gbci_pkg;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 9;
    localparam int VIEW_W  = 12;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [1:0] VERDICT_FREE    = 2'd0;
    localparam logic [1:0] VERDICT_HIT     = 2'd1;
    localparam logic [1:0] VERDICT_NO_ROOM = 2'd2;
    localparam logic [1:0] VERDICT_CLEARED = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]                 operation;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
        logic                       has_second;
        logic signed [COORD_W-1:0]  second_min_x;
        logic signed [COORD_W-1:0]  second_min_y;
        logic signed [COORD_W-1:0]  second_max_x;
        logic signed [COORD_W-1:0]  second_max_y;
    } req_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [COUNT_W-1:0] accepted_count;
    } rsp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } rect_t;

    typedef struct packed {
        rect_t prim;
        rect_t sec;
        logic  has_sec;
    } box_rec_t;

    function automatic logic rects_hit(input rect_t a, input rect_t b);
        rects_hit = (a.x0 < b.x1) && (a.x1 > b.x0) && (a.y0 < b.y1) && (a.y1 > b.y0);
    endfunction

    function automatic logic items_hit(input box_rec_t a, input box_rec_t b);
        items_hit = rects_hit(a.prim, b.prim)
                 || (a.has_sec && rects_hit(a.sec, b.prim))
                 || (b.has_sec && rects_hit(a.prim, b.sec))
                 || (a.has_sec && b.has_sec && rects_hit(a.sec, b.sec));
    endfunction

endpackage

[rtl/gbci_div.sv]
module gbci_div #(
    parameter int DIVISOR = 64,
    parameter int LANES   = 6
) (
    input  logic                            clk,
    input  logic                            start,
    input  logic [LANES-1:0][gbci_pkg::COORD_W-1:0] dividend,
    output logic [LANES-1:0][gbci_pkg::COORD_W-1:0] quotient
);

    localparam int CW = gbci_pkg::COORD_W;
    localparam int LW = $clog2(DIVISOR);
    localparam int SH = CW + LW;
    localparam int MW = CW + 1;
    localparam int PW = CW + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [LANES-1:0][PW-1:0]                prod;
    logic [LANES-1:0][gbci_pkg::COORD_W-1:0] quo_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = PW'(dividend[i]) * PW'(RECIP);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (start)
            begin
                quo_reg[i] <= CW'(prod[i] >> SH);
            end
        end
    end

    assign quotient = quo_reg;

endmodule

[rtl/grid_box_collision_index_unit.sv]
// Channel | Signals                              | Beat taken when
// req     | req_valid, req_stall, req            | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp            | rsp_valid && !rsp_stall
// cfg     | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
// One item at a time. Place/probe: the accept edge also registers the cell
// division, then setup, a fill read per covered cell, slot/box reads and a
// compare per stored index visited, decide, a fill/slot update per cell on
// insert, then the result post; a hit skips the rest. New frame and register
// writes sweep the fill table, as does reset before the first beat is taken.
// A stalled result holds in the output register; the next item may enter.
module grid_box_collision_index_unit #(
    parameter int MAX_BOXES  = 256,
    parameter int CELL_PX    = 64,
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int CELL_SLOTS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  gbci_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output gbci_pkg::rsp_t  rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int CW    = gbci_pkg::COORD_W;
    localparam int NCELL = MAX_COLS * MAX_ROWS;
    localparam int NSLOT = NCELL * CELL_SLOTS;
    localparam int CAW   = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int SAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IW    = $clog2(MAX_BOXES);
    localparam int BCW   = $clog2(MAX_BOXES + 1);
    localparam int KW    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int FW    = $clog2(CELL_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_SETUP, ST_CELL_RD, ST_CELL_WAIT,
        ST_SLOT_RD, ST_BOX_RD, ST_BOX_WAIT, ST_DECIDE, ST_INS_RD, ST_INS_WAIT,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    gbci_pkg::box_rec_t     item_reg;
    logic [1:0]             op_reg;
    logic [3:0]             neg_reg;
    logic [CIW-1:0]         c0_reg, c1_reg, c_reg;
    logic [RIW-1:0]         r0_reg, r1_reg, r_reg;
    logic                   empty_reg;
    logic [FW-1:0]          k_reg, fill_reg;
    logic                   full_reg;
    logic [1:0]             verdict_reg;
    logic [BCW-1:0]         count_reg;
    logic [CAW-1:0]         sweep_reg;
    logic                   clr_pend_reg;
    logic [gbci_pkg::VIEW_W-1:0] vw_reg, vh_reg;
    logic                   rsp_valid_reg;
    gbci_pkg::rsp_t         rsp_reg;

    gbci_pkg::box_rec_t     box_mem [MAX_BOXES];
    logic [IW-1:0]          slot_mem [NSLOT];
    logic [FW-1:0]          fill_mem [NCELL];
    gbci_pkg::box_rec_t     box_q;
    logic [IW-1:0]          slot_q;
    logic [FW-1:0]          fill_q;

    logic                   div_start;
    logic [5:0][CW-1:0]     dividend;
    logic [5:0][CW-1:0]     quo;

    gbci_pkg::box_rec_t     in_rec;
    logic signed [CW-1:0]   ux0, uy0, ux1, uy1;
    logic [CW-1:0]          cols_n, rows_n, last_col, last_row;
    logic [CW-1:0]          cq0, cq1, rq0, rq1;
    logic [CAW-1:0]         cell_addr;
    logic [CAW-1:0]         fill_addr;
    logic [SAW-1:0]         slot_rd_addr, slot_wr_addr;
    logic                   cfg_wr, accept, place_ok, last_cell, rsp_free;
    logic                   fill_we, slot_we, box_we;
    logic [FW-1:0]          fill_wdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == gbci_pkg::REG_HEIGHT) ? 32'(vh_reg) : 32'(vw_reg);

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        in_rec.prim.x0 = req.min_x;
        in_rec.prim.y0 = req.min_y;
        in_rec.prim.x1 = req.max_x;
        in_rec.prim.y1 = req.max_y;
        in_rec.sec.x0  = req.second_min_x;
        in_rec.sec.y0  = req.second_min_y;
        in_rec.sec.x1  = req.second_max_x;
        in_rec.sec.y1  = req.second_max_y;
        in_rec.has_sec = req.has_second;
        ux0 = req.min_x;
        uy0 = req.min_y;
        ux1 = req.max_x;
        uy1 = req.max_y;
        if (req.has_second)
        begin
            if (req.second_min_x < ux0) ux0 = req.second_min_x;
            if (req.second_min_y < uy0) uy0 = req.second_min_y;
            if (req.second_max_x > ux1) ux1 = req.second_max_x;
            if (req.second_max_y > uy1) uy1 = req.second_max_y;
        end
        dividend[0] = ux0[CW-1] ? '0 : ux0;
        dividend[1] = ux1[CW-1] ? '0 : ux1;
        dividend[2] = uy0[CW-1] ? '0 : uy0;
        dividend[3] = uy1[CW-1] ? '0 : uy1;
        dividend[4] = CW'(vw_reg) + CW'(CELL_PX - 1);
        dividend[5] = CW'(vh_reg) + CW'(CELL_PX - 1);
    end

    assign div_start = accept && (req.operation != gbci_pkg::OP_CLEAR);

    gbci_div #(
        .DIVISOR (CELL_PX),
        .LANES   (6)
    ) u_div (
        .clk      (clk),
        .start    (div_start),
        .dividend (dividend),
        .quotient (quo)
    );

    always_comb
    begin
        cols_n   = (quo[4] == '0) ? CW'(1) : ((quo[4] > CW'(MAX_COLS)) ? CW'(MAX_COLS) : quo[4]);
        rows_n   = (quo[5] == '0) ? CW'(1) : ((quo[5] > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : quo[5]);
        last_col = cols_n - CW'(1);
        last_row = rows_n - CW'(1);
        cq0 = neg_reg[0] ? '0 : ((quo[0] > last_col) ? last_col : quo[0]);
        cq1 = neg_reg[1] ? '0 : ((quo[1] > last_col) ? last_col : quo[1]);
        rq0 = neg_reg[2] ? '0 : ((quo[2] > last_row) ? last_row : quo[2]);
        rq1 = neg_reg[3] ? '0 : ((quo[3] > last_row) ? last_row : quo[3]);
    end

    assign cell_addr    = CAW'(r_reg) * CAW'(MAX_COLS) + CAW'(c_reg);
    assign slot_rd_addr = SAW'(cell_addr) * SAW'(CELL_SLOTS) + SAW'(k_reg[KW-1:0]);
    assign slot_wr_addr = SAW'(cell_addr) * SAW'(CELL_SLOTS) + SAW'(fill_q[KW-1:0]);
    assign last_cell    = (c_reg == c1_reg) && (r_reg == r1_reg);
    assign place_ok     = (count_reg < BCW'(MAX_BOXES)) && !full_reg;

    assign fill_we    = (state_reg == ST_SWEEP) || (state_reg == ST_INS_WAIT);
    assign fill_addr  = (state_reg == ST_SWEEP) ? sweep_reg : cell_addr;
    assign fill_wdata = (state_reg == ST_SWEEP) ? '0 : fill_q + FW'(1);
    assign slot_we    = (state_reg == ST_INS_WAIT);
    assign box_we     = (state_reg == ST_DECIDE) && (op_reg == gbci_pkg::OP_PLACE)
                        && place_ok;

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_addr] <= fill_wdata;
        end
        fill_q <= fill_mem[cell_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= count_reg[IW-1:0];
        end
        slot_q <= slot_mem[slot_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (box_we)
        begin
            box_mem[count_reg[IW-1:0]] <= item_reg;
        end
        box_q <= box_mem[slot_q];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            clr_pend_reg  <= 1'b0;
            count_reg     <= '0;
            vw_reg        <= gbci_pkg::VIEW_W'(1024);
            vh_reg        <= gbci_pkg::VIEW_W'(1024);
            rsp_valid_reg <= 1'b0;
            full_reg      <= 1'b0;
            verdict_reg   <= gbci_pkg::VERDICT_FREE;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && (cfg_wr || (state_reg != ST_RESULT)))
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                if (paddr[2] == gbci_pkg::REG_HEIGHT)
                begin
                    vh_reg <= pwdata[gbci_pkg::VIEW_W-1:0];
                end
                else
                begin
                    vw_reg <= pwdata[gbci_pkg::VIEW_W-1:0];
                end
                count_reg    <= '0;
                sweep_reg    <= '0;
                clr_pend_reg <= 1'b0;
                state_reg    <= ST_SWEEP;
            end
            else
            begin
                case (state_reg)
                    ST_SWEEP:
                    begin
                        sweep_reg <= sweep_reg + CAW'(1);
                        if (sweep_reg == CAW'(NCELL - 1))
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_CLEARED;
                            state_reg   <= clr_pend_reg ? ST_RESULT : ST_IDLE;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            item_reg    <= in_rec;
                            op_reg      <= req.operation;
                            neg_reg     <= {uy1[CW-1], uy0[CW-1], ux1[CW-1], ux0[CW-1]};
                            full_reg    <= 1'b0;
                            if (req.operation == gbci_pkg::OP_CLEAR)
                            begin
                                count_reg    <= '0;
                                sweep_reg    <= '0;
                                clr_pend_reg <= 1'b1;
                                state_reg    <= ST_SWEEP;
                            end
                            else
                            begin
                                state_reg <= ST_SETUP;
                            end
                        end
                    end
                    ST_SETUP:
                    begin
                        c0_reg    <= CIW'(cq0);
                        c1_reg    <= CIW'(cq1);
                        r0_reg    <= RIW'(rq0);
                        r1_reg    <= RIW'(rq1);
                        c_reg     <= CIW'(cq0);
                        r_reg     <= RIW'(rq0);
                        empty_reg <= (cq0 > cq1) || (rq0 > rq1);
                        state_reg <= ((cq0 > cq1) || (rq0 > rq1)) ? ST_DECIDE : ST_CELL_RD;
                    end
                    ST_CELL_RD:
                    begin
                        state_reg <= ST_CELL_WAIT;
                    end
                    ST_CELL_WAIT:
                    begin
                        fill_reg <= fill_q;
                        k_reg    <= '0;
                        if (fill_q >= FW'(CELL_SLOTS))
                        begin
                            full_reg <= 1'b1;
                        end
                        if (fill_q != '0)
                        begin
                            state_reg <= ST_SLOT_RD;
                        end
                        else if (last_cell)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                        else
                        begin
                            state_reg <= ST_CELL_RD;
                            if (c_reg == c1_reg)
                            begin
                                c_reg <= c0_reg;
                                r_reg <= r_reg + RIW'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + CIW'(1);
                            end
                        end
                    end
                    ST_SLOT_RD:
                    begin
                        state_reg <= ST_BOX_RD;
                    end
                    ST_BOX_RD:
                    begin
                        state_reg <= ST_BOX_WAIT;
                    end
                    ST_BOX_WAIT:
                    begin
                        k_reg <= k_reg + FW'(1);
                        if (gbci_pkg::items_hit(item_reg, box_q))
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_HIT;
                            state_reg   <= ST_RESULT;
                        end
                        else if ((k_reg + FW'(1) < fill_reg)
                                 && (k_reg + FW'(1) < FW'(CELL_SLOTS)))
                        begin
                            state_reg <= ST_SLOT_RD;
                        end
                        else if (last_cell)
                        begin
                            state_reg <= ST_DECIDE;
                        end
                        else
                        begin
                            state_reg <= ST_CELL_RD;
                            if (c_reg == c1_reg)
                            begin
                                c_reg <= c0_reg;
                                r_reg <= r_reg + RIW'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + CIW'(1);
                            end
                        end
                    end
                    ST_DECIDE:
                    begin
                        c_reg <= c0_reg;
                        r_reg <= r0_reg;
                        if (op_reg != gbci_pkg::OP_PLACE)
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_FREE;
                            state_reg   <= ST_RESULT;
                        end
                        else if (!place_ok)
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_NO_ROOM;
                            state_reg   <= ST_RESULT;
                        end
                        else if (empty_reg)
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_FREE;
                            count_reg   <= count_reg + BCW'(1);
                            state_reg   <= ST_RESULT;
                        end
                        else
                        begin
                            state_reg <= ST_INS_RD;
                        end
                    end
                    ST_INS_RD:
                    begin
                        state_reg <= ST_INS_WAIT;
                    end
                    ST_INS_WAIT:
                    begin
                        if (last_cell)
                        begin
                            verdict_reg <= gbci_pkg::VERDICT_FREE;
                            count_reg   <= count_reg + BCW'(1);
                            state_reg   <= ST_RESULT;
                        end
                        else
                        begin
                            state_reg <= ST_INS_RD;
                            if (c_reg == c1_reg)
                            begin
                                c_reg <= c0_reg;
                                r_reg <= r_reg + RIW'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + CIW'(1);
                            end
                        end
                    end
                    ST_RESULT:
                    begin
                        if (rsp_free)
                        begin
                            rsp_valid_reg          <= 1'b1;
                            rsp_reg.verdict        <= verdict_reg;
                            rsp_reg.accepted_count <= gbci_pkg::COUNT_W'(count_reg);
                            clr_pend_reg           <= 1'b0;
                            state_reg              <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_BOXES = 256;
    localparam int CPX     = 64;
    localparam int NCOLS   = 32;
    localparam int NROWS   = 32;
    localparam int NSLOTS  = 8;
    localparam int CYCLE_LIMIT = 6000000;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    gbci_pkg::req_t   req;
    logic             rsp_valid;
    logic             rsp_stall;
    gbci_pkg::rsp_t   rsp;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    grid_box_collision_index_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // predictor state
    int               view_w;
    int               view_h;
    gbci_pkg::rect_t  kept_prim [N_BOXES];
    gbci_pkg::rect_t  kept_sec  [N_BOXES];
    logic             kept_has  [N_BOXES];
    int               slot_ids  [NCOLS*NROWS][NSLOTS];
    int               slot_fill [NCOLS*NROWS];
    int               kept_count;

    gbci_pkg::rsp_t   pending_verdicts[$];
    int               errors;
    int               cycles;
    int               beats_sent;
    int               beats_seen;
    int               hits_seen;
    int               noroom_seen;
    bit               sender_calm;
    bit               sink_calm;

    function automatic logic signed [gbci_pkg::COORD_W-1:0] to_coord(int v);
        return gbci_pkg::COORD_W'(v);
    endfunction

    function automatic bit overlap(gbci_pkg::rect_t a, gbci_pkg::rect_t b);
        return (a.x0 < b.x1) && (a.x1 > b.x0) && (a.y0 < b.y1) && (a.y1 > b.y0);
    endfunction

    function automatic int span_of(int px, int lim);
        int n;
        n = (px + CPX - 1) / CPX;
        if (n < 1) n = 1;
        if (n > lim) n = lim;
        return n;
    endfunction

    function automatic int cell_of(int v, int n);
        int c;
        c = v / CPX;
        if (c < 0) c = 0;
        if (c > n - 1) c = n - 1;
        return c;
    endfunction

    task automatic wipe_index();
        for (int i = 0; i < NCOLS*NROWS; i++) slot_fill[i] = 0;
        kept_count = 0;
    endtask

    task automatic predict_verdict(input gbci_pkg::req_t it, output gbci_pkg::rsp_t res);
        gbci_pkg::rect_t p;
        gbci_pkg::rect_t s;
        bit    hs;
        bit    hit;
        bit    full;
        int    ux0, uy0, ux1, uy1, cols, rows, c0, c1, r0, r1, cell_no, id;
        hit = 0;
        full = 0;
        if (it.operation == gbci_pkg::OP_CLEAR) begin
            wipe_index();
            res.verdict = gbci_pkg::VERDICT_CLEARED;
            res.accepted_count = '0;
            return;
        end
        p = '{it.min_x, it.min_y, it.max_x, it.max_y};
        s = '{it.second_min_x, it.second_min_y, it.second_max_x, it.second_max_y};
        hs = it.has_second;
        ux0 = int'(p.x0); uy0 = int'(p.y0); ux1 = int'(p.x1); uy1 = int'(p.y1);
        if (hs) begin
            if (int'(s.x0) < ux0) ux0 = int'(s.x0);
            if (int'(s.y0) < uy0) uy0 = int'(s.y0);
            if (int'(s.x1) > ux1) ux1 = int'(s.x1);
            if (int'(s.y1) > uy1) uy1 = int'(s.y1);
        end
        cols = span_of(view_w, NCOLS);
        rows = span_of(view_h, NROWS);
        c0 = cell_of(ux0, cols); c1 = cell_of(ux1, cols);
        r0 = cell_of(uy0, rows); r1 = cell_of(uy1, rows);
        for (int r = r0; r <= r1 && !hit; r++) begin
            for (int c = c0; c <= c1 && !hit; c++) begin
                cell_no = r * cols + c;
                if (slot_fill[cell_no] >= NSLOTS) full = 1;
                for (int k = 0; k < slot_fill[cell_no] && k < NSLOTS && !hit; k++) begin
                    id = slot_ids[cell_no][k];
                    if (overlap(p, kept_prim[id])
                        || (hs && overlap(s, kept_prim[id]))
                        || (kept_has[id] && overlap(p, kept_sec[id]))
                        || (hs && kept_has[id] && overlap(s, kept_sec[id])))
                        hit = 1;
                end
            end
        end
        if (hit) begin
            res.verdict = gbci_pkg::VERDICT_HIT;
        end else if (it.operation == gbci_pkg::OP_PLACE) begin
            if (kept_count >= N_BOXES || full) begin
                res.verdict = gbci_pkg::VERDICT_NO_ROOM;
            end else begin
                kept_prim[kept_count] = p;
                kept_sec[kept_count] = s;
                kept_has[kept_count] = hs;
                for (int r = r0; r <= r1; r++) begin
                    for (int c = c0; c <= c1; c++) begin
                        cell_no = r * cols + c;
                        slot_ids[cell_no][slot_fill[cell_no]] = kept_count;
                        slot_fill[cell_no]++;
                    end
                end
                kept_count++;
                res.verdict = gbci_pkg::VERDICT_FREE;
            end
        end else begin
            res.verdict = gbci_pkg::VERDICT_FREE;
        end
        res.accepted_count = kept_count[gbci_pkg::COUNT_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 beats_seen);
    endtask

    // result checker and sink stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("tb_top failed");
                $finish;
            end
            if (rsp_valid && !rsp_stall) begin
                beats_seen++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected beat", int'(rsp.verdict), -1);
                end else begin
                    gbci_pkg::rsp_t want;
                    want = pending_verdicts.pop_front();
                    if (rsp.verdict == gbci_pkg::VERDICT_HIT) hits_seen++;
                    if (rsp.verdict == gbci_pkg::VERDICT_NO_ROOM) noroom_seen++;
                    if (rsp.verdict !== want.verdict)
                        report_mismatch("verdict", int'(rsp.verdict), int'(want.verdict));
                    if (rsp.accepted_count !== want.accepted_count)
                        report_mismatch("accepted_count", int'(rsp.accepted_count),
                                        int'(want.accepted_count));
                end
            end
            rsp_stall <= sink_calm ? 1'b0 : ($urandom_range(99) < 10);
        end
    end

    task automatic send_item(input gbci_pkg::req_t it);
        gbci_pkg::rsp_t want;
        while (!sender_calm && $urandom_range(99) < 10) @(posedge clk);
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_verdict(it, want);
        pending_verdicts = {pending_verdicts, want};
        beats_sent++;
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_sel, input int value);
        drain_results();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_sel == gbci_pkg::REG_WIDTH) view_w = value & 12'hFFF;
        else view_h = value & 12'hFFF;
        wipe_index();
        repeat (1200) @(posedge clk);
    endtask

    function automatic gbci_pkg::req_t make_box(logic [1:0] op, int x, int y, int w, int h);
        gbci_pkg::req_t it;
        it = '0;
        it.operation = op;
        it.min_x = to_coord(x); it.min_y = to_coord(y);
        it.max_x = to_coord(x + w); it.max_y = to_coord(y + h);
        return it;
    endfunction

    function automatic gbci_pkg::req_t random_item(int span);
        gbci_pkg::req_t it;
        int   roll;
        it = make_box($urandom_range(99) < 70 ? gbci_pkg::OP_PLACE : gbci_pkg::OP_PROBE,
                      int'($urandom_range(span)) - 40, int'($urandom_range(span)) - 40,
                      int'($urandom_range(90)), int'($urandom_range(60)));
        roll = $urandom_range(99);
        if (roll < 3) it.operation = gbci_pkg::OP_CLEAR;
        else if (roll < 6) it.operation = gbci_pkg::OP_SPARE;
        if ($urandom_range(99) < 35) begin
            it.has_second = 1'b1;
            it.second_min_x = to_coord(int'(it.max_x) + int'($urandom_range(30)));
            it.second_min_y = to_coord(int'(it.min_y) + int'($urandom_range(20)));
            it.second_max_x = to_coord(int'(it.second_min_x) + int'($urandom_range(80)));
            it.second_max_y = to_coord(int'(it.second_min_y) + int'($urandom_range(40)));
        end else begin
            it.second_min_x = to_coord(int'($urandom));
            it.second_min_y = to_coord(int'($urandom));
            it.second_max_x = to_coord(int'($urandom));
            it.second_max_y = to_coord(int'($urandom));
        end
        if ($urandom_range(99) < 4) begin
            it.min_x = to_coord(int'($urandom)); it.min_y = to_coord(int'($urandom));
            it.max_x = to_coord(int'($urandom)); it.max_y = to_coord(int'($urandom));
        end
        return it;
    endfunction

    task automatic test_directed_edges();
        gbci_pkg::req_t it;
        send_item(make_box(gbci_pkg::OP_PLACE, 10, 10, 20, 20));
        send_item(make_box(gbci_pkg::OP_PROBE, 30, 10, 10, 10));
        send_item(make_box(gbci_pkg::OP_PROBE, 29, 29, 10, 10));
        send_item(make_box(gbci_pkg::OP_PLACE, 25, 25, 2, 2));
        send_item(make_box(gbci_pkg::OP_SPARE, 0, 0, 100, 100));
        send_item(make_box(gbci_pkg::OP_PLACE, 500, 500, -20, 10));
        it = make_box(gbci_pkg::OP_PLACE, 200, 200, 10, 10);
        it.has_second = 1'b1;
        it.second_min_x = to_coord(300); it.second_min_y = to_coord(200);
        it.second_max_x = to_coord(340); it.second_max_y = to_coord(230);
        send_item(it);
        send_item(make_box(gbci_pkg::OP_PROBE, 320, 210, 5, 5));
        it = make_box(gbci_pkg::OP_PLACE, -32768, -32768, 0, 0);
        it.max_x = 16'sh7FFF; it.max_y = 16'sh7FFF;
        send_item(it);
        it.min_x = 16'sh7FFF; it.min_y = 16'sh7FFF;
        it.max_x = to_coord(-32768); it.max_y = to_coord(-32768);
        it.has_second = 1'b1;
        it.second_min_x = 16'sh7FFF; it.second_min_y = to_coord(-32768);
        it.second_max_x = to_coord(-32768); it.second_max_y = 16'sh7FFF;
        send_item(it);
        send_item(make_box(gbci_pkg::OP_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < 9; i++)
            send_item(make_box(gbci_pkg::OP_PLACE, 1 + 6*i, 1, 4, 4));
        send_item(make_box(gbci_pkg::OP_PLACE, 2, 2, 2, 2));
        send_item(make_box(gbci_pkg::OP_CLEAR, 0, 0, 0, 0));
    endtask

    task automatic test_store_full();
        for (int i = 0; i < 270; i++)
            send_item(make_box(gbci_pkg::OP_PLACE, (i % 32) * 64 + 8, (i / 32) * 64 + 8,
                               20, 20));
        send_item(make_box(gbci_pkg::OP_PLACE, 0, 0, 2, 2));
        send_item(make_box(gbci_pkg::OP_PROBE, 10, 10, 4, 4));
        send_item(make_box(gbci_pkg::OP_CLEAR, 0, 0, 0, 0));
    endtask

    task automatic test_random_phase(input int count, input int span);
        for (int i = 0; i < count; i++) send_item(random_item(span));
    endtask

    initial begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; cycles = 0; beats_sent = 0; beats_seen = 0;
        hits_seen = 0; noroom_seen = 0;
        sender_calm = 1'b0; sink_calm = 1'b0;
        view_w = 1024; view_h = 1024;
        wipe_index();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        write_reg(gbci_pkg::REG_WIDTH, 2048);
        write_reg(gbci_pkg::REG_HEIGHT, 2048);
        test_store_full();
        test_random_phase(300, 600);
        drain_results();
        write_reg(gbci_pkg::REG_WIDTH, 1);
        write_reg(gbci_pkg::REG_HEIGHT, 0);
        test_random_phase(100, 300);
        write_reg(gbci_pkg::REG_WIDTH, 4095);
        write_reg(gbci_pkg::REG_HEIGHT, 130);
        sender_calm = 1'b1; sink_calm = 1'b1;
        test_random_phase(200, 2200);
        sender_calm = 1'b0; sink_calm = 1'b0;
        write_reg(gbci_pkg::REG_WIDTH, 700);
        write_reg(gbci_pkg::REG_HEIGHT, 1024);
        test_random_phase(250, 500);

        drain_results();
        $display("covered %0d sent and %0d returned beats: %0d collisions, %0d no-room",
                 beats_sent, beats_seen, hits_seen, noroom_seen);
        $display("viewport extremes, full store, full cells and clears were exercised");
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
